// ===== hdl/mve_pkg.sv =====
// Shared types, codes and constants for the map viewport extractor.
`timescale 1ns / 1ps
`default_nettype none

package mve_pkg;

   // Default geometry (map and window, in pixels)
   localparam int MAP_COLUMNS_DEFAULT  = 512;
   localparam int MAP_ROWS_DEFAULT     = 256;
   localparam int VIEW_COLUMNS_DEFAULT = 64;
   localparam int VIEW_ROWS_DEFAULT    = 32;

   // Map store: byte-wide, fixed depth
   localparam int MEM_DEPTH  = 16384;
   localparam int MEM_ADDR_W = 14;
   // Linear pixel address, kept modulo 8 * MEM_DEPTH
   localparam int LIN_W      = MEM_ADDR_W + 3;

   // Field widths fixed by the interface
   localparam int ROW_INDEX_W = 5;
   localparam int PIXELS_W    = 64;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // Position arithmetic widths
   localparam int DIFF_W  = 26;   // coordinate minus reference
   localparam int SCALE_W = 32;   // signed Q0.32 scale (32 fraction bits)
   localparam int PROD_W  = DIFF_W + SCALE_W;
   localparam int POS_W   = 17;   // signed window origin / map row

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_VIEW  = 1'b1
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_REF_PIXEL_X   = 3'd0,
      CSR_REF_PIXEL_Y   = 3'd1,
      CSR_REF_LONGITUDE = 3'd2,
      CSR_REF_LATITUDE  = 3'd3,
      CSR_SCALE_X       = 3'd4,
      CSR_SCALE_Y       = 3'd5
   } csr_reg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF_X,
      ST_MUL_X,
      ST_POS_X,
      ST_DIFF_Y,
      ST_MUL_Y,
      ST_POS_Y,
      ST_DIFF_ROW,
      ST_MUL_ROW,
      ST_BASE,
      ST_FETCH,
      ST_EMIT
   } state_type;

   // Operand select for the shared multiplier
   typedef enum logic [1:0] {
      DIFF_LON,
      DIFF_LAT,
      DIFF_ROW
   } diff_sel_type;

   // Controller to datapath commands
   typedef struct packed {
      logic                   mem_write;
      logic                   load_view;
      logic                   diff_en;
      diff_sel_type           diff_sel;
      logic                   mul_en;
      logic                   pos_x_en;
      logic                   pos_y_en;
      logic                   base_en;
      logic                   issue;
      logic                   capture;
      logic                   emit;
      logic                   next_row;
      logic                   last_row;
      logic [ROW_INDEX_W-1:0] row_index;
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic out_busy;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== hdl/mve_ctrl.sv =====
// Sequencer for the map viewport extractor: position math, row fetch and emit.
`timescale 1ns / 1ps
`default_nettype none

module mve_ctrl #(
   parameter int VIEW_COLUMNS = mve_pkg::VIEW_COLUMNS_DEFAULT,
   parameter int VIEW_ROWS    = mve_pkg::VIEW_ROWS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_opcode,
   output logic                  req_ready,
   input  mve_pkg::dp_status_type status,
   output mve_pkg::dp_cmd_type    cmd
);
   import mve_pkg::*;

   // Bytes read per window row (covers any bit offset)
   localparam int NUM_BYTES = (VIEW_COLUMNS + 14) / 8;
   localparam int FETCH_W   = $clog2(NUM_BYTES + 1);
   localparam int ROW_W     = (VIEW_ROWS > 1) ? $clog2(VIEW_ROWS) : 1;

   state_type            state_ff, state_in;
   logic [FETCH_W-1:0]   fetch_cnt_ff, fetch_cnt_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic                 last_row;
   logic [ROW_W+ROW_INDEX_W-1:0] row_ext;

   assign last_row = (row_ff == ROW_W'(VIEW_ROWS - 1));
   assign row_ext  = {{ROW_INDEX_W{1'b0}}, row_ff};

   // Next state and counters
   always_comb begin
      state_in     = state_ff;
      fetch_cnt_in = fetch_cnt_ff;
      row_in       = row_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && (req_opcode == OP_VIEW)) state_in = ST_DIFF_X;
         end
         ST_DIFF_X:   state_in = ST_MUL_X;
         ST_MUL_X:    state_in = ST_POS_X;
         ST_POS_X:    state_in = ST_DIFF_Y;
         ST_DIFF_Y:   state_in = ST_MUL_Y;
         ST_MUL_Y:    state_in = ST_POS_Y;
         ST_POS_Y:    state_in = ST_DIFF_ROW;
         ST_DIFF_ROW: state_in = ST_MUL_ROW;
         ST_MUL_ROW:  state_in = ST_BASE;
         ST_BASE: begin
            state_in     = ST_FETCH;
            fetch_cnt_in = '0;
            row_in       = '0;
         end
         ST_FETCH: begin
            if (fetch_cnt_ff == FETCH_W'(NUM_BYTES)) begin
               state_in = ST_EMIT;
            end else begin
               fetch_cnt_in = fetch_cnt_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (!status.out_busy) begin
               if (last_row) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in     = ST_FETCH;
                  fetch_cnt_in = '0;
                  row_in       = row_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Command decode
   always_comb begin
      cmd           = '0;
      cmd.diff_sel  = DIFF_LON;
      cmd.last_row  = last_row;
      cmd.row_index = row_ext[ROW_INDEX_W-1:0];
      req_ready     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.mem_write = req_valid && (req_opcode == OP_WRITE);
            cmd.load_view = req_valid && (req_opcode == OP_VIEW);
         end
         ST_DIFF_X: begin
            cmd.diff_en  = 1'b1;
            cmd.diff_sel = DIFF_LON;
         end
         ST_DIFF_Y: begin
            cmd.diff_en  = 1'b1;
            cmd.diff_sel = DIFF_LAT;
         end
         ST_DIFF_ROW: begin
            cmd.diff_en  = 1'b1;
            cmd.diff_sel = DIFF_ROW;
         end
         ST_MUL_X, ST_MUL_Y, ST_MUL_ROW: cmd.mul_en = 1'b1;
         ST_POS_X: cmd.pos_x_en = 1'b1;
         ST_POS_Y: cmd.pos_y_en = 1'b1;
         ST_BASE:  cmd.base_en  = 1'b1;
         ST_FETCH: begin
            cmd.issue   = (fetch_cnt_ff < FETCH_W'(NUM_BYTES));
            cmd.capture = (fetch_cnt_ff != '0);
         end
         ST_EMIT: begin
            cmd.emit     = !status.out_busy;
            cmd.next_row = !status.out_busy;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fetch_cnt_ff <= '0;
         row_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         fetch_cnt_ff <= fetch_cnt_in;
         row_ff       <= row_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/mve_datapath.sv =====
// Datapath: config registers, map memory, position multiplier, row assembly.
`timescale 1ns / 1ps
`default_nettype none

module mve_datapath #(
   parameter int MAP_COLUMNS  = mve_pkg::MAP_COLUMNS_DEFAULT,
   parameter int MAP_ROWS     = mve_pkg::MAP_ROWS_DEFAULT,
   parameter int VIEW_COLUMNS = mve_pkg::VIEW_COLUMNS_DEFAULT,
   parameter int VIEW_ROWS    = mve_pkg::VIEW_ROWS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mve_pkg::dp_cmd_type                 cmd,
   output mve_pkg::dp_status_type              status,
   input  logic                                csr_write_enable,
   input  logic [mve_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mve_pkg::CSR_DATA_W-1:0]      csr_write_data,
   input  logic [mve_pkg::MEM_ADDR_W-1:0]      req_map_address,
   input  logic [7:0]                          req_map_data,
   input  logic signed [23:0]                  req_latitude,
   input  logic signed [24:0]                  req_longitude,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [mve_pkg::ROW_INDEX_W-1:0]     rsp_row_index,
   output logic [mve_pkg::PIXELS_W-1:0]        rsp_row_pixels,
   output logic                                rsp_last_row
);
   import mve_pkg::*;

   localparam int NUM_BYTES = (VIEW_COLUMNS + 14) / 8;
   localparam int BUF_W     = NUM_BYTES * 8;

   // Calibration registers
   logic signed [15:0] ref_pixel_x_ff, ref_pixel_y_ff;
   logic signed [24:0] ref_longitude_ff;
   logic signed [23:0] ref_latitude_ff;
   logic signed [31:0] scale_x_ff, scale_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_pixel_x_ff   <= '0;
         ref_pixel_y_ff   <= '0;
         ref_longitude_ff <= '0;
         ref_latitude_ff  <= '0;
         scale_x_ff       <= '0;
         scale_y_ff       <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_REF_PIXEL_X:   ref_pixel_x_ff   <= csr_write_data[15:0];
            CSR_REF_PIXEL_Y:   ref_pixel_y_ff   <= csr_write_data[15:0];
            CSR_REF_LONGITUDE: ref_longitude_ff <= csr_write_data[24:0];
            CSR_REF_LATITUDE:  ref_latitude_ff  <= csr_write_data[23:0];
            CSR_SCALE_X:       scale_x_ff       <= csr_write_data;
            CSR_SCALE_Y:       scale_y_ff       <= csr_write_data;
            default: ;
         endcase
      end
   end

   // View coordinates, held for the whole view
   logic signed [23:0] lat_ff;
   logic signed [24:0] lon_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_view) begin
         lat_ff <= req_latitude;
         lon_ff <= req_longitude;
      end
   end

   // Shared multiplier: operand stage, then product stage
   logic signed [DIFF_W-1:0]  diff_ff, diff_in;
   logic signed [SCALE_W-1:0] mul_b_ff, mul_b_in;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [POS_W-1:0]   sx_ff, my_ff;

   always_comb begin
      diff_in  = {{(DIFF_W-17){my_ff[POS_W-1]}}, my_ff};
      mul_b_in = SCALE_W'(MAP_COLUMNS);
      case (cmd.diff_sel)
         DIFF_LON: begin
            diff_in  = {lon_ff[24], lon_ff} - {ref_longitude_ff[24], ref_longitude_ff};
            mul_b_in = scale_x_ff;
         end
         DIFF_LAT: begin
            diff_in  = {{2{lat_ff[23]}}, lat_ff}
                     - {{2{ref_latitude_ff[23]}}, ref_latitude_ff};
            mul_b_in = scale_y_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.diff_en) begin
         diff_ff  <= diff_in;
         mul_b_ff <= mul_b_in;
      end
      if (cmd.mul_en) prod_ff <= diff_ff * mul_b_ff;
   end

   // Position: cal + floor(product / 2^32), saturated to 16 bits signed
   logic signed [15:0] cal;
   logic signed [26:0] pos_sum;
   logic signed [15:0] pos_sat;

   assign cal     = cmd.pos_x_en ? ref_pixel_x_ff : ref_pixel_y_ff;
   assign pos_sum = {{11{cal[15]}}, cal} + {prod_ff[PROD_W-1], prod_ff[PROD_W-1:32]};

   always_comb begin
      if (!pos_sum[26] && (pos_sum[25:15] != '0)) begin
         pos_sat = 16'sh7fff;
      end else if (pos_sum[26] && (pos_sum[25:15] != '1)) begin
         pos_sat = -16'sh8000;
      end else begin
         pos_sat = pos_sum[15:0];
      end
   end

   // Row walk: linear pixel address of the window's left edge, map row
   logic [LIN_W-1:0]      row_lin_ff, row_lin_in;
   logic [MEM_ADDR_W-1:0] rd_addr_ff, rd_addr_in;
   logic signed [POS_W-1:0] sx_in, my_in;

   always_comb begin
      sx_in = sx_ff;
      my_in = my_ff;
      if (cmd.pos_x_en) sx_in = {pos_sat[15], pos_sat} - POS_W'(VIEW_COLUMNS / 2);
      if (cmd.pos_y_en) my_in = {pos_sat[15], pos_sat} - POS_W'(VIEW_ROWS / 2);
      if (cmd.next_row) my_in = my_ff + 1'b1;

      row_lin_in = row_lin_ff;
      if (cmd.base_en) begin
         row_lin_in = prod_ff[LIN_W-1:0] + sx_ff[LIN_W-1:0];
      end else if (cmd.next_row) begin
         row_lin_in = row_lin_ff + LIN_W'(MAP_COLUMNS);
      end

      rd_addr_in = rd_addr_ff;
      if (cmd.issue) begin
         rd_addr_in = rd_addr_ff + 1'b1;
      end else if (cmd.base_en || cmd.next_row) begin
         rd_addr_in = row_lin_in[LIN_W-1:3];
      end
   end

   always_ff @(posedge clock) begin
      sx_ff      <= sx_in;
      my_ff      <= my_in;
      row_lin_ff <= row_lin_in;
      rd_addr_ff <= rd_addr_in;
   end

   // Column mask, once per view: window pixel x is on the map
   logic [VIEW_COLUMNS-1:0] col_mask_ff;

   always_ff @(posedge clock) begin
      if (cmd.base_en) begin
         for (int x = 0; x < VIEW_COLUMNS; x++) begin
            logic signed [POS_W-1:0] mx;
            mx = sx_ff + POS_W'(x);
            col_mask_ff[VIEW_COLUMNS-1-x] <= !mx[POS_W-1]
                                             && ($unsigned(mx) < POS_W'(MAP_COLUMNS));
         end
      end
   end

   // Map memory: write at the write beat, registered read for the fetch
   logic [7:0] mem [MEM_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.mem_write) mem[req_map_address] <= req_map_data;
      if (cmd.issue) rd_data_ff <= mem[rd_addr_ff];
   end

   // Byte buffer, first byte ends up at the top
   logic [BUF_W-1:0] buf_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) buf_ff <= {buf_ff[BUF_W-9:0], rd_data_ff};
   end

   // Align to the bit offset, mask off-map pixels, left-justify
   logic [BUF_W-1:0]        aligned;
   logic [VIEW_COLUMNS-1:0] window;
   logic                    row_ok;
   logic [PIXELS_W-1:0]     pixels;

   assign aligned = buf_ff << row_lin_ff[2:0];
   assign row_ok  = !my_ff[POS_W-1] && ($unsigned(my_ff) < POS_W'(MAP_ROWS));
   assign window  = aligned[BUF_W-1 -: VIEW_COLUMNS] & col_mask_ff & {VIEW_COLUMNS{row_ok}};
   assign pixels  = PIXELS_W'(window) << (PIXELS_W - VIEW_COLUMNS);

   // Output register
   logic                   rsp_valid_ff;
   logic [ROW_INDEX_W-1:0] rsp_row_index_ff;
   logic [PIXELS_W-1:0]    rsp_row_pixels_ff;
   logic                   rsp_last_row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_row_index_ff  <= cmd.row_index;
         rsp_row_pixels_ff <= pixels;
         rsp_last_row_ff   <= cmd.last_row;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_row_index   = rsp_row_index_ff;
   assign rsp_row_pixels  = rsp_row_pixels_ff;
   assign rsp_last_row    = rsp_last_row_ff;
   assign status.out_busy = rsp_valid_ff && !rsp_ready;

endmodule

`default_nettype wire

// ===== hdl/map_viewport_extract.sv =====
// Top level of the map viewport extractor: 1 bpp map store and window readout.
//
//  Channel  Direction  Beat contents
//  req_     in         opcode, map_address, map_data, latitude, longitude
//  rsp_     out        row_index, row_pixels, last_row (one beat per window row)
//  csr_     in         write_enable, index, write_data (no handshake)
//
//  A map write is a single beat. A view runs the position math (one shared
//  26x32 multiplier, three passes) and then reads NB = (VIEW_COLUMNS + 14) / 8
//  bytes per window row through the single read port of the map memory.
//  Reset is synchronous; the map memory is not cleared.
//  A held rsp_ beat stalls the next row; req_ is taken again once the last
//  row sits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module map_viewport_extract #(
   parameter int MAP_COLUMNS  = mve_pkg::MAP_COLUMNS_DEFAULT,
   parameter int MAP_ROWS     = mve_pkg::MAP_ROWS_DEFAULT,
   parameter int VIEW_COLUMNS = mve_pkg::VIEW_COLUMNS_DEFAULT,
   parameter int VIEW_ROWS    = mve_pkg::VIEW_ROWS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [mve_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [mve_pkg::CSR_DATA_W-1:0]   csr_write_data,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_opcode,
   input  logic [mve_pkg::MEM_ADDR_W-1:0]   req_map_address,
   input  logic [7:0]                       req_map_data,
   input  logic signed [23:0]               req_latitude,
   input  logic signed [24:0]               req_longitude,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [mve_pkg::ROW_INDEX_W-1:0]  rsp_row_index,
   output logic [mve_pkg::PIXELS_W-1:0]     rsp_row_pixels,
   output logic                             rsp_last_row
);
   import mve_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   mve_ctrl #(
      .VIEW_COLUMNS (VIEW_COLUMNS),
      .VIEW_ROWS    (VIEW_ROWS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_ready  (req_ready),
      .status     (status),
      .cmd        (cmd)
   );

   mve_datapath #(
      .MAP_COLUMNS  (MAP_COLUMNS),
      .MAP_ROWS     (MAP_ROWS),
      .VIEW_COLUMNS (VIEW_COLUMNS),
      .VIEW_ROWS    (VIEW_ROWS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_map_address  (req_map_address),
      .req_map_data     (req_map_data),
      .req_latitude     (req_latitude),
      .req_longitude    (req_longitude),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_row_index    (rsp_row_index),
      .rsp_row_pixels   (rsp_row_pixels),
      .rsp_last_row     (rsp_last_row)
   );

   // A row is never loaded over a beat still waiting at the output
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !(rsp_valid && !rsp_ready))
      else $error("row loaded over a pending output beat");

   // Memory fetch and row emit never overlap
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.emit && (cmd.issue || cmd.capture)))
      else $error("fetch active during row emit");

   // The final row of a view carries the last window row number
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_row) |-> (rsp_row_index == ROW_INDEX_W'(VIEW_ROWS - 1)))
      else $error("last_row on a row other than the final one");

   // No new item is taken while a view is still being worked
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit && !cmd.last_row |=> !req_ready)
      else $error("input accepted in the middle of a view");

endmodule

`default_nettype wire
